// ----- sv/rlhw_pkg.sv -----
// Package for the radio link health watchdog.
// Holds the transfer payload types, command and cause codes, register indexes and reset values.
// No dependencies; every other file of the block uses it.
package rlhw_pkg;

   typedef enum logic [2:0] {
      CMD_TX_VERDICT = 3'd0,
      CMD_RX_FRAME   = 3'd1,
      CMD_POLL       = 3'd2,
      CMD_RELAUNCHED = 3'd3,
      CMD_CLEAR      = 3'd4,
      CMD_READ_HIST  = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      TX_ACKED       = 2'd0,
      TX_MAX_RETRIES = 2'd1,
      TX_TIMEOUT     = 2'd2,
      TX_REFUSED     = 2'd3
   } tx_kind_type;

   typedef enum logic [1:0] {
      CAUSE_NONE       = 2'd0,
      CAUSE_VERIFY     = 2'd1,
      CAUSE_TX_TIMEOUT = 2'd2,
      CAUSE_RX_NOISE   = 2'd3
   } cause_type;

   typedef enum logic [2:0] {
      REG_NOISE_MIN_FRAMES  = 3'd0,
      REG_NOISE_BAD_PERCENT = 3'd1,
      REG_NOISE_WINDOW_MS   = 3'd2,
      REG_TIMEOUT_RUN_LIMIT = 3'd3,
      REG_FRUITLESS_LIMIT   = 3'd4,
      REG_HOLDOFF_MS        = 3'd5
   } reg_index_type;

   localparam int HISTORY_DEPTH_DEF = 8;

   localparam logic [15:0] NOISE_MIN_FRAMES_RST  = 16'd20;
   localparam logic [6:0]  NOISE_BAD_PERCENT_RST = 7'd50;
   localparam logic [30:0] NOISE_WINDOW_MS_RST   = 31'd1000;
   localparam logic [7:0]  TIMEOUT_RUN_LIMIT_RST = 8'd3;
   localparam logic [7:0]  FRUITLESS_LIMIT_RST   = 8'd3;
   localparam logic [31:0] HOLDOFF_MS_RST        = 32'd10000;

   localparam logic [7:0]  RUN_MAX   = 8'hFF;
   localparam logic [15:0] COUNT_MAX = 16'hFFFF;
   localparam logic [6:0]  PERCENT_SCALE = 7'd100;

   typedef struct packed {
      cmd_type     command;
      tx_kind_type tx_kind;
      logic        crc_good;
      logic [31:0] now_ms;
      cause_type   relaunch_cause;
      logic [2:0]  history_slot;
   } req_type;

   typedef struct packed {
      logic [1:0]  due_cause;
      logic        failed;
      logic [31:0] wait_left_ms;
      logic [31:0] total_relaunches;
      logic        history_valid;
      logic [1:0]  history_cause;
      logic [31:0] history_time_ms;
   } rsp_type;

   // Request from the event logic to the history ring
   typedef struct packed {
      logic        write;
      logic        clear;
      logic        read;
      logic [1:0]  cause;
      logic [31:0] time_ms;
      logic [2:0]  slot;
   } hist_req_type;

   // Registered lookup result from the history ring
   typedef struct packed {
      logic        valid;
      logic [1:0]  cause;
      logic [31:0] time_ms;
   } hist_rsp_type;

endpackage

// ----- sv/radio_link_health_watchdog_top.sv -----
// Top level of the radio link health watchdog.
// Event logic, configuration registers and a two-deep result path; uses rlhw_pkg, rlhw_history.
// Every request yields exactly one response.
//
// Watches a radio chip and tells software when to relaunch it. Every request transfer
// (tx verdict, rx frame, poll, relaunched, clear counts, read history) produces exactly
// one response transfer, registered in stage A and then in the output register; a new
// request is accepted every cycle unless a stalled response side keeps stage A full.
// All scalar health state updates in the accepting cycle; the relaunch history lives
// in a synchronous memory with a registered read. Two result slots (the history read
// stage and the output register) let the block take a request while a finished
// response is still waiting. The user must write configuration registers through the
// csr port only while the block is idle; the block itself does not enforce it. They
// take effect on the next request. After reset the block is ready at once; history
// entries never written are never reported since the fill count guards every read.
module radio_link_health_watchdog_top #(
   parameter int HISTORY_DEPTH = rlhw_pkg::HISTORY_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rlhw_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rlhw_pkg::rsp_type rsp_data,
   input  logic              csr_write_en,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_wdata
);

   // Configuration registers
   logic [15:0] cfg_min_frames_ff;
   logic [6:0]  cfg_bad_percent_ff;
   logic [30:0] cfg_window_ff;
   logic [7:0]  cfg_run_limit_ff;
   logic [7:0]  cfg_fruitless_ff;
   logic [31:0] cfg_holdoff_ff;

   // Health state
   logic [7:0]  run_ff, run_in;
   logic        win_open_ff, win_open_in;
   logic        flooded_ff, flooded_in;
   logic [31:0] win_start_ff, win_start_in;
   logic [15:0] frames_ff, frames_in;
   logic [15:0] bad_ff, bad_in;
   logic        alarm_ff, alarm_in;
   logic [7:0]  unrec_ff, unrec_in;
   logic        failed_ff, failed_in;
   logic        holding_ff, holding_in;
   logic [31:0] last_ff, last_in;
   // Only the sum of the per-cause counts is ever reported, so keep the sum.
   logic [31:0] total_ff, total_in;

   // Result path: stage A waits for the history read, then the output register
   logic                   a_valid_ff;
   rlhw_pkg::rsp_type      a_data_ff, a_data_in;
   logic                   rsp_valid_ff;
   rlhw_pkg::rsp_type      rsp_data_ff, rsp_data_in;
   logic                   a_move;
   logic                   req_take;
   rlhw_pkg::hist_req_type hreq;
   rlhw_pkg::hist_rsp_type hrsp;

   // Per-request working values
   logic [31:0] age;
   logic [31:0] gone;
   logic [23:0] bad_scaled;
   logic [23:0] frames_scaled;
   logic [1:0]  symptom;

   assign a_move    = a_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = a_valid_ff && !a_move;
   assign req_take  = req_valid && !req_stall;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_min_frames_ff  <= rlhw_pkg::NOISE_MIN_FRAMES_RST;
         cfg_bad_percent_ff <= rlhw_pkg::NOISE_BAD_PERCENT_RST;
         cfg_window_ff      <= rlhw_pkg::NOISE_WINDOW_MS_RST;
         cfg_run_limit_ff   <= rlhw_pkg::TIMEOUT_RUN_LIMIT_RST;
         cfg_fruitless_ff   <= rlhw_pkg::FRUITLESS_LIMIT_RST;
         cfg_holdoff_ff     <= rlhw_pkg::HOLDOFF_MS_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            rlhw_pkg::REG_NOISE_MIN_FRAMES:  cfg_min_frames_ff  <= csr_wdata[15:0];
            rlhw_pkg::REG_NOISE_BAD_PERCENT: cfg_bad_percent_ff <= csr_wdata[6:0];
            rlhw_pkg::REG_NOISE_WINDOW_MS:   cfg_window_ff      <= csr_wdata[30:0];
            rlhw_pkg::REG_TIMEOUT_RUN_LIMIT: cfg_run_limit_ff   <= csr_wdata[7:0];
            rlhw_pkg::REG_FRUITLESS_LIMIT:   cfg_fruitless_ff   <= csr_wdata[7:0];
            rlhw_pkg::REG_HOLDOFF_MS:        cfg_holdoff_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Event logic: next state for the request on the input port
   always_comb begin
      run_in       = run_ff;
      win_open_in  = win_open_ff;
      flooded_in   = flooded_ff;
      win_start_in = win_start_ff;
      frames_in    = frames_ff;
      bad_in       = bad_ff;
      alarm_in     = alarm_ff;
      unrec_in     = unrec_ff;
      failed_in    = failed_ff;
      holding_in   = holding_ff;
      last_in      = last_ff;
      total_in     = total_ff;
      hreq         = '0;
      hreq.cause   = req_data.relaunch_cause;
      hreq.time_ms = req_data.now_ms;
      hreq.slot    = req_data.history_slot;
      a_data_in    = '0;
      symptom      = rlhw_pkg::CAUSE_NONE;
      bad_scaled    = 24'd0;
      frames_scaled = 24'd0;

      age = req_data.now_ms - win_start_ff;

      // Rx frames and polls first close or open the observation window
      if (req_data.command == rlhw_pkg::CMD_RX_FRAME ||
          req_data.command == rlhw_pkg::CMD_POLL) begin
         if (!win_open_ff || age >= {1'b0, cfg_window_ff}) begin
            if (win_open_ff) begin
               // Overdue by two windows: the last window saw nothing, drop the alarm
               alarm_in = flooded_ff && ({1'b0, age} < {1'b0, cfg_window_ff, 1'b0});
               if (!flooded_ff && ({1'b0, bad_ff} << 1) < {1'b0, frames_ff}) begin
                  unrec_in  = 8'd0;
                  failed_in = 1'b0;
               end
            end
            win_open_in  = 1'b1;
            flooded_in   = 1'b0;
            win_start_in = req_data.now_ms;
            frames_in    = 16'd0;
            bad_in       = 16'd0;
         end
      end

      case (req_data.command)
         rlhw_pkg::CMD_TX_VERDICT: begin
            case (req_data.tx_kind)
               rlhw_pkg::TX_ACKED: begin
                  run_in    = 8'd0;
                  unrec_in  = 8'd0;
                  failed_in = 1'b0;
               end
               rlhw_pkg::TX_MAX_RETRIES: run_in = 8'd0;
               rlhw_pkg::TX_TIMEOUT: begin
                  if (run_ff < rlhw_pkg::RUN_MAX) begin
                     run_in = run_ff + 8'd1;
                  end
               end
               default: ;
            endcase
         end
         rlhw_pkg::CMD_RX_FRAME: begin
            if (frames_in < rlhw_pkg::COUNT_MAX) begin
               frames_in = frames_in + 16'd1;
            end
            if (!req_data.crc_good && bad_in < rlhw_pkg::COUNT_MAX) begin
               bad_in = bad_in + 16'd1;
            end
            bad_scaled    = 24'(bad_in) * 24'(rlhw_pkg::PERCENT_SCALE);
            frames_scaled = 24'(frames_in) * 24'(cfg_bad_percent_ff);
            if (!flooded_in && frames_in >= cfg_min_frames_ff &&
                bad_scaled >= frames_scaled) begin
               flooded_in = 1'b1;
               alarm_in   = 1'b1;
            end
         end
         rlhw_pkg::CMD_POLL: begin
            if (holding_ff && (req_data.now_ms - last_ff) >= cfg_holdoff_ff) begin
               holding_in = 1'b0;
            end
            if (run_ff >= cfg_run_limit_ff) begin
               symptom = rlhw_pkg::CAUSE_TX_TIMEOUT;
            end else if (alarm_in) begin
               symptom = rlhw_pkg::CAUSE_RX_NOISE;
            end
            if (symptom != rlhw_pkg::CAUSE_NONE) begin
               if (unrec_in >= cfg_fruitless_ff) begin
                  failed_in = 1'b1;
               end
               a_data_in.due_cause = holding_in ? rlhw_pkg::CAUSE_NONE : symptom;
            end
         end
         rlhw_pkg::CMD_RELAUNCHED: begin
            holding_in = 1'b1;
            last_in    = req_data.now_ms;
            if (unrec_ff < rlhw_pkg::RUN_MAX) begin
               unrec_in = unrec_ff + 8'd1;
            end
            if (req_data.relaunch_cause != rlhw_pkg::CAUSE_NONE) begin
               total_in   = total_ff + 32'd1;
               hreq.write = 1'b1;
            end
            run_in       = 8'd0;
            alarm_in     = 1'b0;
            win_open_in  = 1'b1;
            flooded_in   = 1'b0;
            win_start_in = req_data.now_ms;
            frames_in    = 16'd0;
            bad_in       = 16'd0;
         end
         rlhw_pkg::CMD_CLEAR: begin
            total_in   = 32'd0;
            hreq.clear = 1'b1;
         end
         rlhw_pkg::CMD_READ_HIST: hreq.read = 1'b1;
         default: ;
      endcase

      // Status reported after the command
      gone = req_data.now_ms - last_in;
      a_data_in.failed           = failed_in;
      a_data_in.wait_left_ms     = (holding_in && gone < cfg_holdoff_ff) ?
                                   cfg_holdoff_ff - gone : 32'd0;
      a_data_in.total_relaunches = total_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff       <= 8'd0;
         win_open_ff  <= 1'b0;
         flooded_ff   <= 1'b0;
         win_start_ff <= 32'd0;
         frames_ff    <= 16'd0;
         bad_ff       <= 16'd0;
         alarm_ff     <= 1'b0;
         unrec_ff     <= 8'd0;
         failed_ff    <= 1'b0;
         holding_ff   <= 1'b0;
         last_ff      <= 32'd0;
         total_ff     <= 32'd0;
      end else if (req_take) begin
         run_ff       <= run_in;
         win_open_ff  <= win_open_in;
         flooded_ff   <= flooded_in;
         win_start_ff <= win_start_in;
         frames_ff    <= frames_in;
         bad_ff       <= bad_in;
         alarm_ff     <= alarm_in;
         unrec_ff     <= unrec_in;
         failed_ff    <= failed_in;
         holding_ff   <= holding_in;
         last_ff      <= last_in;
         total_ff     <= total_in;
      end
   end

   rlhw_history #(
      .HISTORY_DEPTH(HISTORY_DEPTH)
   ) u_history (
      .clock(clock),
      .reset(reset),
      .load (req_take),
      .hreq (hreq),
      .hrsp (hrsp)
   );

   // Stage A: hold the status while the history read lands
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (req_take) begin
         a_valid_ff <= 1'b1;
      end else if (a_move) begin
         a_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         a_data_ff <= a_data_in;
      end
   end

   // Merge the history lookup into the waiting status
   always_comb begin
      rsp_data_in                 = a_data_ff;
      rsp_data_in.history_valid   = hrsp.valid;
      rsp_data_in.history_cause   = hrsp.cause;
      rsp_data_in.history_time_ms = hrsp.time_ms;
   end

   // Output register: advance when empty or when the transfer completes
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (a_move) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (a_move) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- sv/rlhw_history.sv -----
// Relaunch history ring for the radio link health watchdog.
// One synchronous memory of cause/time entries plus write pointer and fill count.
// Depends on rlhw_pkg.
module rlhw_history #(
   parameter int HISTORY_DEPTH = rlhw_pkg::HISTORY_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  rlhw_pkg::hist_req_type hreq,
   output rlhw_pkg::hist_rsp_type hrsp
);

   localparam int IW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int FW = $clog2(HISTORY_DEPTH + 1);
   localparam logic [7:0]    DEPTH_W  = 8'(HISTORY_DEPTH);
   localparam logic [7:0]    DEPTH_M1 = 8'(HISTORY_DEPTH - 1);
   localparam logic [IW-1:0] LAST_IDX = IW'(HISTORY_DEPTH - 1);
   localparam logic [FW-1:0] FULL     = FW'(HISTORY_DEPTH);

   typedef struct packed {
      logic [1:0]  cause;
      logic [31:0] time_ms;
   } entry_type;

   entry_type     mem [HISTORY_DEPTH];
   entry_type     rd_data_ff;
   logic          rd_valid_ff;
   logic          rd_valid_in;
   logic [IW-1:0] next_ff, next_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [7:0]    idx_sum;
   logic [IW-1:0] rd_idx;

   // Newest entry sits one behind the write pointer; walk back by slot.
   always_comb begin
      idx_sum = 8'(next_ff) + DEPTH_M1 - 8'(hreq.slot);
      if (idx_sum >= DEPTH_W) begin
         idx_sum = idx_sum - DEPTH_W;
      end
      rd_idx = idx_sum[IW-1:0];
      rd_valid_in = hreq.read && (8'(hreq.slot) < 8'(fill_ff));
   end

   always_comb begin
      next_in = next_ff;
      fill_in = fill_ff;
      if (hreq.clear) begin
         next_in = '0;
         fill_in = '0;
      end else if (hreq.write) begin
         next_in = (next_ff == LAST_IDX) ? '0 : next_ff + 1'b1;
         if (fill_ff < FULL) begin
            fill_in = fill_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_ff     <= '0;
         fill_ff     <= '0;
         rd_valid_ff <= 1'b0;
      end else if (load) begin
         next_ff     <= next_in;
         fill_ff     <= fill_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rd_data_ff <= mem[rd_idx];
         if (hreq.write) begin
            mem[next_ff] <= '{cause: hreq.cause, time_ms: hreq.time_ms};
         end
      end
   end

   assign hrsp.valid   = rd_valid_ff;
   assign hrsp.cause   = rd_valid_ff ? rd_data_ff.cause : 2'd0;
   assign hrsp.time_ms = rd_valid_ff ? rd_data_ff.time_ms : 32'd0;

endmodule

// ----- sim/radio_link_health_watchdog_top_tb.sv -----
// Self-checking testbench for radio_link_health_watchdog_top.
// Drives request transfers and checks every response against an in-bench model of the
// watchdog's health state; depends on rlhw_pkg and the RTL only.
`timescale 1ns / 1ps

module radio_link_health_watchdog_top_tb;

   // Sizing and run limits
   localparam int HIST_DEPTH        = rlhw_pkg::HISTORY_DEPTH_DEF;
   localparam int RUN_LIMIT_CYCLES  = 200000;
   localparam int SETTLE_CYCLES     = 4;    // response path: stage A, then the output register
   localparam int TAIL_CYCLES       = 10;

   // Command codes the block does not implement
   localparam logic [2:0] CMD_RESERVED_LO = 3'd6;
   localparam logic [2:0] CMD_RESERVED_HI = 3'd7;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_pattern_type;

   // DUT signals; every input starts at a known value
   logic              clock        = 1'b0;
   logic              reset        = 1'b1;
   logic              req_valid    = 1'b0;
   logic              req_stall;
   rlhw_pkg::req_type req_data     = '0;
   logic              rsp_valid;
   logic              rsp_stall    = 1'b0;
   rlhw_pkg::rsp_type rsp_data;
   logic              csr_write_en = 1'b0;
   logic [2:0]        csr_index    = '0;
   logic [31:0]       csr_wdata    = '0;

   radio_link_health_watchdog_top u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------
   // Model of the watchdog: configuration copy and health state
   // ---------------------------------------------------------------------------------
   logic [15:0] cfg_min_frames;
   logic [6:0]  cfg_bad_percent;
   logic [30:0] cfg_window_ms;
   logic [7:0]  cfg_run_limit;
   logic [7:0]  cfg_fruitless_limit;
   logic [31:0] cfg_holdoff_ms;

   logic [7:0]  tx_timeout_run;
   logic        win_open;
   logic        win_flooded;
   logic [31:0] win_start;
   logic [15:0] win_frames;
   logic [15:0] win_bad;
   logic        noise_alarm;
   logic [7:0]  futile_relaunches;
   logic        give_up_flag;
   logic        holdoff_active;
   logic [31:0] last_relaunch_ms;
   logic [31:0] relaunch_count [4];
   rlhw_pkg::cause_type ring_cause [HIST_DEPTH];
   logic [31:0] ring_time [HIST_DEPTH];
   logic [2:0]  ring_next;
   logic [3:0]  ring_fill;

   // Responses still owed by the block, oldest first
   rlhw_pkg::rsp_type expected_status [$];

   int unsigned mismatch_count = 0;
   int unsigned rsp_seen       = 0;
   int unsigned cycle_count    = 0;
   int unsigned burst_left     = 0;
   logic [31:0] sim_now        = '0;

   stall_pattern_type stall_mode = STALL_NONE;
   int unsigned       stall_span = 0;
   int unsigned       stall_tick = 0;

   task automatic reset_health_model();
      cfg_min_frames      = rlhw_pkg::NOISE_MIN_FRAMES_RST;
      cfg_bad_percent     = rlhw_pkg::NOISE_BAD_PERCENT_RST;
      cfg_window_ms       = rlhw_pkg::NOISE_WINDOW_MS_RST;
      cfg_run_limit       = rlhw_pkg::TIMEOUT_RUN_LIMIT_RST;
      cfg_fruitless_limit = rlhw_pkg::FRUITLESS_LIMIT_RST;
      cfg_holdoff_ms      = rlhw_pkg::HOLDOFF_MS_RST;
      tx_timeout_run      = '0;
      win_open            = 1'b0;
      win_flooded         = 1'b0;
      win_start           = '0;
      win_frames          = '0;
      win_bad             = '0;
      noise_alarm         = 1'b0;
      futile_relaunches   = '0;
      give_up_flag        = 1'b0;
      holdoff_active      = 1'b0;
      last_relaunch_ms    = '0;
      foreach (relaunch_count[i]) relaunch_count[i] = '0;
      foreach (ring_cause[i]) ring_cause[i] = rlhw_pkg::CAUSE_NONE;
      foreach (ring_time[i]) ring_time[i] = '0;
      ring_next           = '0;
      ring_fill           = '0;
   endtask

   function automatic void clear_fruitless();
      futile_relaunches = '0;
      give_up_flag      = 1'b0;
   endfunction

   function automatic void window_restart(logic [31:0] now);
      win_open    = 1'b1;
      win_flooded = 1'b0;
      win_start   = now;
      win_frames  = '0;
      win_bad     = '0;
   endfunction

   // Close the running window if its time is up; a window overdue by two lengths
   // stands for an empty one, so the alarm drops
   function automatic void window_roll(logic [31:0] now);
      logic [31:0] age;
      if (!win_open) begin
         window_restart(now);
         return;
      end
      age = now - win_start;
      if (age < cfg_window_ms) return;
      noise_alarm = win_flooded && (age < {cfg_window_ms, 1'b0});
      if (!win_flooded && (32'(win_bad) * 2 < 32'(win_frames))) clear_fruitless();
      window_restart(now);
   endfunction

   // Advance the model by one request and return the response it owes
   function automatic rlhw_pkg::rsp_type predict_status(rlhw_pkg::req_type r);
      rlhw_pkg::rsp_type   s;
      rlhw_pkg::cause_type symptom_cause;
      logic [31:0] gone;
      logic [31:0] total;
      int unsigned slot_idx;
      s = '0;
      case (r.command)
         rlhw_pkg::CMD_TX_VERDICT: begin
            case (r.tx_kind)
               rlhw_pkg::TX_ACKED: begin
                  tx_timeout_run = '0;
                  clear_fruitless();
               end
               rlhw_pkg::TX_MAX_RETRIES: tx_timeout_run = '0;
               rlhw_pkg::TX_TIMEOUT:
                  if (tx_timeout_run != rlhw_pkg::RUN_MAX) tx_timeout_run++;
               default: ;
            endcase
         end
         rlhw_pkg::CMD_RX_FRAME: begin
            window_roll(r.now_ms);
            if (win_frames != rlhw_pkg::COUNT_MAX) win_frames++;
            if (!r.crc_good && win_bad != rlhw_pkg::COUNT_MAX) win_bad++;
            if (!win_flooded && win_frames >= cfg_min_frames &&
                32'(win_bad) * 32'(rlhw_pkg::PERCENT_SCALE) >=
                32'(win_frames) * 32'(cfg_bad_percent)) begin
               win_flooded = 1'b1;
               noise_alarm = 1'b1;
            end
         end
         rlhw_pkg::CMD_POLL: begin
            window_roll(r.now_ms);
            gone = r.now_ms - last_relaunch_ms;
            if (holdoff_active && gone >= cfg_holdoff_ms) holdoff_active = 1'b0;
            if (tx_timeout_run >= cfg_run_limit) symptom_cause = rlhw_pkg::CAUSE_TX_TIMEOUT;
            else if (noise_alarm) symptom_cause = rlhw_pkg::CAUSE_RX_NOISE;
            else symptom_cause = rlhw_pkg::CAUSE_NONE;
            if (symptom_cause != rlhw_pkg::CAUSE_NONE) begin
               if (futile_relaunches >= cfg_fruitless_limit) give_up_flag = 1'b1;
               s.due_cause = holdoff_active ? rlhw_pkg::CAUSE_NONE : symptom_cause;
            end
         end
         rlhw_pkg::CMD_RELAUNCHED: begin
            holdoff_active   = 1'b1;
            last_relaunch_ms = r.now_ms;
            if (futile_relaunches != rlhw_pkg::RUN_MAX) futile_relaunches++;
            if (r.relaunch_cause != rlhw_pkg::CAUSE_NONE) begin
               relaunch_count[r.relaunch_cause]++;
               ring_cause[ring_next] = r.relaunch_cause;
               ring_time[ring_next]  = r.now_ms;
               ring_next = 3'((int'(ring_next) + 1) % HIST_DEPTH);
               if (ring_fill < HIST_DEPTH) ring_fill++;
            end
            tx_timeout_run = '0;
            noise_alarm    = 1'b0;
            window_restart(r.now_ms);
         end
         rlhw_pkg::CMD_CLEAR: begin
            foreach (relaunch_count[i]) relaunch_count[i] = '0;
            ring_next = '0;
            ring_fill = '0;
         end
         rlhw_pkg::CMD_READ_HIST: begin
            if (r.history_slot < ring_fill) begin
               slot_idx = (int'(ring_next) + HIST_DEPTH - 1 - int'(r.history_slot))
                          % HIST_DEPTH;
               s.history_valid   = 1'b1;
               s.history_cause   = ring_cause[slot_idx];
               s.history_time_ms = ring_time[slot_idx];
            end
         end
         default: ;
      endcase
      s.failed = give_up_flag;
      gone = r.now_ms - last_relaunch_ms;
      s.wait_left_ms = (!holdoff_active || gone >= cfg_holdoff_ms) ? '0 : cfg_holdoff_ms - gone;
      total = '0;
      foreach (relaunch_count[i]) total += relaunch_count[i];
      s.total_relaunches = total;
      return s;
   endfunction

   // ---------------------------------------------------------------------------------
   // Response side: stall pattern and checker
   // ---------------------------------------------------------------------------------

   // Switch stall pattern at random intervals so back-pressure lands on every
   // stage of the response path, with quiet stretches in between
   always @(negedge clock) begin
      if (stall_span == 0) begin
         stall_mode = stall_pattern_type'($urandom_range(0, 3));
         stall_span = $urandom_range(20, 200);
      end else begin
         stall_span--;
      end
      stall_tick++;
      case (stall_mode)
         STALL_NONE:     rsp_stall <= 1'b0;
         STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY:    rsp_stall <= ($urandom_range(0, 3) != 0);
         STALL_PERIODIC: rsp_stall <= (stall_tick % 5 < 2);
         default:        rsp_stall <= 1'b0;
      endcase
   end

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t: response %0d: %s got 0x%0h want 0x%0h", $realtime, rsp_seen, what,
               got, want);
      mismatch_count++;
   endtask

   // Compare each response transfer with the oldest owed response
   always @(posedge clock) begin
      rlhw_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_status.size() == 0) begin
            report_mismatch("response with none owed", 32'(rsp_data), '0);
         end else begin
            want = expected_status.pop_front();
            if (rsp_data.due_cause !== want.due_cause)
               report_mismatch("due_cause", 32'(rsp_data.due_cause), 32'(want.due_cause));
            if (rsp_data.failed !== want.failed)
               report_mismatch("give_up", 32'(rsp_data.failed), 32'(want.failed));
            if (rsp_data.wait_left_ms !== want.wait_left_ms)
               report_mismatch("wait_left_ms", rsp_data.wait_left_ms, want.wait_left_ms);
            if (rsp_data.total_relaunches !== want.total_relaunches)
               report_mismatch("total_relaunches", rsp_data.total_relaunches,
                               want.total_relaunches);
            if (rsp_data.history_valid !== want.history_valid)
               report_mismatch("history_valid", 32'(rsp_data.history_valid),
                               32'(want.history_valid));
            if (rsp_data.history_cause !== want.history_cause)
               report_mismatch("history_cause", 32'(rsp_data.history_cause),
                               32'(want.history_cause));
            if (rsp_data.history_time_ms !== want.history_time_ms)
               report_mismatch("history_time_ms", rsp_data.history_time_ms,
                               want.history_time_ms);
         end
         rsp_seen++;
      end
   end

   // Give up on a hung block
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT_CYCLES) begin
         $display("FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------------------

   function automatic rlhw_pkg::req_type make_req(rlhw_pkg::cmd_type cmd,
                                                  rlhw_pkg::tx_kind_type tx, logic crc,
                                                  logic [31:0] now,
                                                  rlhw_pkg::cause_type cause,
                                                  logic [2:0] slot);
      rlhw_pkg::req_type r;
      r.command        = cmd;
      r.tx_kind        = tx;
      r.crc_good       = crc;
      r.now_ms         = now;
      r.relaunch_cause = cause;
      r.history_slot   = slot;
      return r;
   endfunction

   // Send one request transfer; the sender works in bursts, and between bursts it
   // drops valid for a random gap
   task automatic send_request(rlhw_pkg::req_type r);
      int unsigned gap;
      gap = 0;
      if (burst_left == 0) begin
         gap        = $urandom_range(1, 6);
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                  : $urandom_range(1, 16);
      end
      burst_left--;
      if (gap != 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= r;
      // hold the payload until the block takes it
      do @(posedge clock); while (req_stall);
      expected_status.push_back(predict_status(r));
   endtask

   // Drop valid and wait for every owed response, then let the pipe settle
   task automatic hold_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_status.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write one register; the caller makes sure the block is idle
   task automatic write_setting(rlhw_pkg::reg_index_type idx, logic [31:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         rlhw_pkg::REG_NOISE_MIN_FRAMES:  cfg_min_frames      = value[15:0];
         rlhw_pkg::REG_NOISE_BAD_PERCENT: cfg_bad_percent     = value[6:0];
         rlhw_pkg::REG_NOISE_WINDOW_MS:   cfg_window_ms       = value[30:0];
         rlhw_pkg::REG_TIMEOUT_RUN_LIMIT: cfg_run_limit       = value[7:0];
         rlhw_pkg::REG_FRUITLESS_LIMIT:   cfg_fruitless_limit = value[7:0];
         rlhw_pkg::REG_HOLDOFF_MS:        cfg_holdoff_ms      = value;
         default: ;
      endcase
   endtask

   task automatic apply_settings(logic [31:0] min_frames, logic [31:0] bad_percent,
                                 logic [31:0] window_ms, logic [31:0] run_limit,
                                 logic [31:0] fruitless, logic [31:0] holdoff);
      hold_until_drained();
      write_setting(rlhw_pkg::REG_NOISE_MIN_FRAMES, min_frames);
      write_setting(rlhw_pkg::REG_NOISE_BAD_PERCENT, bad_percent);
      write_setting(rlhw_pkg::REG_NOISE_WINDOW_MS, window_ms);
      write_setting(rlhw_pkg::REG_TIMEOUT_RUN_LIMIT, run_limit);
      write_setting(rlhw_pkg::REG_FRUITLESS_LIMIT, fruitless);
      write_setting(rlhw_pkg::REG_HOLDOFF_MS, holdoff);
   endtask

   // Mostly a coherent event stream: time moves forward in small steps so windows fill
   // and flood, with occasional long silences and a few out-of-order time stamps
   task automatic random_traffic(int unsigned count);
      rlhw_pkg::req_type r;
      int unsigned pick;
      int unsigned bad_share;
      logic [31:0] advance_cap;
      bad_share = 0;
      for (int unsigned n = 0; n < count; n++) begin
         // vary the error rate so windows range from clean to flooded
         if (n % 12 == 0) begin
            case ($urandom_range(0, 3))
               0:       bad_share = 0;
               1:       bad_share = 30;
               2:       bad_share = 70;
               default: bad_share = 100;
            endcase
         end
         advance_cap = (cfg_window_ms > 31'd8000) ? 32'd500 : 32'(cfg_window_ms) / 16 + 1;
         pick = $urandom_range(0, 99);
         if (pick < 3)
            sim_now = sim_now + 32'(cfg_window_ms) + $urandom_range(0, 32'(cfg_window_ms) * 2);
         else if (pick < 5)
            sim_now = $urandom();
         else
            sim_now = sim_now + $urandom_range(0, advance_cap);

         r.now_ms         = sim_now;
         r.crc_good       = ($urandom_range(0, 99) >= bad_share);
         r.relaunch_cause = rlhw_pkg::cause_type'($urandom_range(0, 3));
         r.history_slot   = 3'($urandom_range(0, 7));
         pick = $urandom_range(0, 99);
         if (pick < 45)      r.tx_kind = rlhw_pkg::TX_TIMEOUT;
         else if (pick < 65) r.tx_kind = rlhw_pkg::TX_ACKED;
         else if (pick < 85) r.tx_kind = rlhw_pkg::TX_MAX_RETRIES;
         else                r.tx_kind = rlhw_pkg::TX_REFUSED;

         pick = $urandom_range(0, 99);
         if (pick < 40)      r.command = rlhw_pkg::CMD_RX_FRAME;
         else if (pick < 60) r.command = rlhw_pkg::CMD_TX_VERDICT;
         else if (pick < 75) r.command = rlhw_pkg::CMD_POLL;
         else if (pick < 85) r.command = rlhw_pkg::CMD_RELAUNCHED;
         else if (pick < 96) r.command = rlhw_pkg::CMD_READ_HIST;
         else if (pick < 98) r.command = rlhw_pkg::CMD_CLEAR;
         else r.command = rlhw_pkg::cmd_type'(($urandom_range(0, 1) == 0) ? CMD_RESERVED_LO
                                                                          : CMD_RESERVED_HI);
         send_request(r);
      end
   endtask

   // ---------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------

   // Timeout run builds up, a refused frame leaves it alone, a poll reports it
   task automatic test_tx_timeouts();
      send_request(make_req(rlhw_pkg::CMD_TX_VERDICT, rlhw_pkg::TX_TIMEOUT, 1'b1, 32'd0,
                            rlhw_pkg::CAUSE_NONE, 3'd0));
      send_request(make_req(rlhw_pkg::CMD_TX_VERDICT, rlhw_pkg::TX_REFUSED, 1'b1, 32'd1,
                            rlhw_pkg::CAUSE_NONE, 3'd0));
      send_request(make_req(rlhw_pkg::CMD_TX_VERDICT, rlhw_pkg::TX_TIMEOUT, 1'b1, 32'd2,
                            rlhw_pkg::CAUSE_NONE, 3'd0));
      send_request(make_req(rlhw_pkg::CMD_TX_VERDICT, rlhw_pkg::TX_TIMEOUT, 1'b1, 32'd3,
                            rlhw_pkg::CAUSE_NONE, 3'd0));
      send_request(make_req(rlhw_pkg::CMD_POLL, rlhw_pkg::TX_ACKED, 1'b1, 32'd5,
                            rlhw_pkg::CAUSE_NONE, 3'd0));
      send_request(make_req(rlhw_pkg::CMD_TX_VERDICT, rlhw_pkg::TX_MAX_RETRIES, 1'b0, 32'd6,
                            rlhw_pkg::CAUSE_NONE, 3'd0));
      send_request(make_req(rlhw_pkg::CMD_TX_VERDICT, rlhw_pkg::TX_ACKED, 1'b0, 32'd7,
                            rlhw_pkg::CAUSE_NONE, 3'd0));
   endtask

   // Flood a short window, poll the alarm, then let the window go stale across the
   // time wrap so the alarm drops
   task automatic test_noise_flood();
      hold_until_drained();
      write_setting(rlhw_pkg::REG_NOISE_MIN_FRAMES, 32'd2);
      write_setting(rlhw_pkg::REG_NOISE_WINDOW_MS, 32'd100);
      send_request(make_req(rlhw_pkg::CMD_RX_FRAME, rlhw_pkg::TX_ACKED, 1'b0, 32'd10,
                            rlhw_pkg::CAUSE_NONE, 3'd0));
      send_request(make_req(rlhw_pkg::CMD_RX_FRAME, rlhw_pkg::TX_ACKED, 1'b0, 32'd20,
                            rlhw_pkg::CAUSE_NONE, 3'd0));
      send_request(make_req(rlhw_pkg::CMD_POLL, rlhw_pkg::TX_ACKED, 1'b1, 32'd30,
                            rlhw_pkg::CAUSE_NONE, 3'd0));
      send_request(make_req(rlhw_pkg::CMD_RX_FRAME, rlhw_pkg::TX_ACKED, 1'b1, 32'hFFFF_FFFF,
                            rlhw_pkg::CAUSE_NONE, 3'd0));
      send_request(make_req(rlhw_pkg::CMD_POLL, rlhw_pkg::TX_ACKED, 1'b1, 32'h0000_0040,
                            rlhw_pkg::CAUSE_NONE, 3'd0));
   endtask

   // Relaunch with every cause (none leaves no record), read back filled and empty
   // slots, try the unused commands, clear and read again
   task automatic test_relaunch_history();
      send_request(make_req(rlhw_pkg::CMD_RELAUNCHED, rlhw_pkg::TX_ACKED, 1'b1, 32'd100,
                            rlhw_pkg::CAUSE_NONE, 3'd0));
      send_request(make_req(rlhw_pkg::CMD_RELAUNCHED, rlhw_pkg::TX_ACKED, 1'b1, 32'd200,
                            rlhw_pkg::CAUSE_VERIFY, 3'd0));
      send_request(make_req(rlhw_pkg::CMD_RELAUNCHED, rlhw_pkg::TX_ACKED, 1'b1, 32'd300,
                            rlhw_pkg::CAUSE_TX_TIMEOUT, 3'd0));
      send_request(make_req(rlhw_pkg::CMD_RELAUNCHED, rlhw_pkg::TX_ACKED, 1'b1, 32'd400,
                            rlhw_pkg::CAUSE_RX_NOISE, 3'd0));
      send_request(make_req(rlhw_pkg::CMD_READ_HIST, rlhw_pkg::TX_ACKED, 1'b1, 32'd410,
                            rlhw_pkg::CAUSE_NONE, 3'd0));
      send_request(make_req(rlhw_pkg::CMD_READ_HIST, rlhw_pkg::TX_ACKED, 1'b1, 32'd420,
                            rlhw_pkg::CAUSE_NONE, 3'd2));
      send_request(make_req(rlhw_pkg::CMD_READ_HIST, rlhw_pkg::TX_ACKED, 1'b1, 32'd430,
                            rlhw_pkg::CAUSE_NONE, 3'd3));
      send_request(make_req(rlhw_pkg::CMD_READ_HIST, rlhw_pkg::TX_ACKED, 1'b1, 32'd440,
                            rlhw_pkg::CAUSE_NONE, 3'd7));
      send_request(make_req(rlhw_pkg::cmd_type'(CMD_RESERVED_LO), rlhw_pkg::TX_TIMEOUT,
                            1'b0, 32'd450, rlhw_pkg::CAUSE_RX_NOISE, 3'd0));
      send_request(make_req(rlhw_pkg::cmd_type'(CMD_RESERVED_HI), rlhw_pkg::TX_TIMEOUT,
                            1'b0, 32'd460, rlhw_pkg::CAUSE_RX_NOISE, 3'd0));
      send_request(make_req(rlhw_pkg::CMD_CLEAR, rlhw_pkg::TX_ACKED, 1'b1, 32'd470,
                            rlhw_pkg::CAUSE_NONE, 3'd0));
      send_request(make_req(rlhw_pkg::CMD_READ_HIST, rlhw_pkg::TX_ACKED, 1'b1, 32'd480,
                            rlhw_pkg::CAUSE_NONE, 3'd0));
   endtask

   // A symptom after too many relaunches without recovery sets the flag while the
   // holdoff hides the cause; an acknowledged frame clears it
   task automatic test_fruitless_relaunches();
      hold_until_drained();
      write_setting(rlhw_pkg::REG_TIMEOUT_RUN_LIMIT, 32'd1);
      send_request(make_req(rlhw_pkg::CMD_TX_VERDICT, rlhw_pkg::TX_TIMEOUT, 1'b1, 32'd490,
                            rlhw_pkg::CAUSE_NONE, 3'd0));
      send_request(make_req(rlhw_pkg::CMD_POLL, rlhw_pkg::TX_ACKED, 1'b1, 32'd500,
                            rlhw_pkg::CAUSE_NONE, 3'd0));
      send_request(make_req(rlhw_pkg::CMD_TX_VERDICT, rlhw_pkg::TX_ACKED, 1'b1, 32'd510,
                            rlhw_pkg::CAUSE_NONE, 3'd0));
   endtask

   // Top, bottom and zero of every register, each followed by a stretch of traffic
   task automatic test_register_extremes();
      apply_settings(32'hFFFF, 32'd100, 32'h7FFF_FFFF, 32'd255, 32'd255, 32'hFFFF_FFFF);
      sim_now = 32'hFFFF_FF00;
      random_traffic(40);
      apply_settings(32'd1, 32'd0, 32'd1, 32'd1, 32'd1, 32'd0);
      random_traffic(40);
      apply_settings(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
      random_traffic(40);
   endtask

   // Several random settings, one phase near the time wrap, and one mid-phase pause
   // until every owed response is back
   task automatic test_random_traffic();
      for (int unsigned phase = 0; phase < 6; phase++) begin
         apply_settings($urandom_range(1, 8), $urandom_range(20, 80), $urandom_range(50, 400),
                        $urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(0, 1500));
         if (phase == 2) sim_now = 32'hFFFF_F000;
         random_traffic(55);
         if (phase == 3) hold_until_drained();
         random_traffic(55);
      end
   endtask

   initial begin
      reset_health_model();
      // hold reset, then release it at a falling edge
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_tx_timeouts();
      test_noise_flood();
      test_relaunch_history();
      test_fruitless_relaunches();
      test_register_extremes();
      test_random_traffic();

      hold_until_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ----- files.f -----
sv/rlhw_pkg.sv
sv/rlhw_history.sv
sv/radio_link_health_watchdog_top.sv
sim/radio_link_health_watchdog_top_tb.sv
